@@ sv/dpb_pkg.sv @@
// ============================================================================
// dpb_pkg
// Shared types, widths and constants for the depth pixel back-projection
// block.
// ============================================================================
`default_nettype none

package dpb_pkg;

    // Largest frame the column and row counters are built for.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Field widths.
    localparam int DIM_W    = 11;
    localparam int FOCAL_W  = 24;
    localparam int VDIST_W  = 32;
    localparam int DEPTH_W  = 16;
    localparam int MAG_W    = DEPTH_W - 1;
    localparam int COORD_W  = 25;
    localparam int GRAY_W   = 16;
    localparam int FRAC_W   = 24;

    // Counter and datapath widths.
    localparam int CNT_W   = $clog2(MAX_WIDTH);
    localparam int RCNT_W  = $clog2(MAX_HEIGHT);
    localparam int HALF_W  = DIM_W - 1;
    localparam int CNT_MAX_W = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;
    localparam int OFS_W   = ((CNT_MAX_W > HALF_W) ? CNT_MAX_W : HALF_W) + 1;
    localparam int CMP_W   = ((CNT_MAX_W + 1) > DIM_W) ? (CNT_MAX_W + 1) : DIM_W;
    localparam int PD_W    = OFS_W + MAG_W + 1;
    localparam int PP_W    = PD_W + FOCAL_W + 1;
    localparam int T_W     = MAG_W + VDIST_W;

    // Integer part of a rounded Q24 product magnitude.
    localparam int M_W     = PP_W + 1 - FRAC_W;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Q24     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_INV_VIEW_DIST_Q32 = CFG_IDX_W'(3);

    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH   = DIM_W'(640);
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT  = DIM_W'(480);
    localparam logic [FOCAL_W-1:0] RST_INV_FOCAL     = FOCAL_W'(29418);
    localparam logic [VDIST_W-1:0] RST_INV_VIEW_DIST = VDIST_W'(2147484);

    typedef struct packed {
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [FOCAL_W-1:0] inv_focal_q24;
        logic [VDIST_W-1:0] inv_view_distance_q32;
    } cfg_t;

    // One valid pixel handed from the front to the back.
    typedef struct packed {
        logic signed [OFS_W-1:0] ofs_x;
        logic signed [OFS_W-1:0] ofs_y;
        logic [MAG_W-1:0]        depth;
    } qitem_t;

endpackage

`default_nettype wire

@@ sv/dpb_pixel_if.sv @@
// ============================================================================
// dpb_pixel_if
// Depth pixel channel: valid/ready handshake with depth and frame start.
// ============================================================================
`default_nettype none

interface dpb_pixel_if
    import dpb_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DEPTH_W-1:0] depth_mm;
    logic                      frame_start;

    modport source (output valid, output depth_mm, output frame_start, input ready);
    modport sink   (input valid, input depth_mm, input frame_start, output ready);
endinterface

`default_nettype wire

@@ sv/dpb_point_if.sv @@
// ============================================================================
// dpb_point_if
// Point channel: valid/ready handshake with one back-projected point.
// ============================================================================
`default_nettype none

interface dpb_point_if
    import dpb_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x_mm;
    logic signed [COORD_W-1:0] point_y_mm;
    logic signed [DEPTH_W-1:0] point_z_mm;
    logic [GRAY_W-1:0]         gray_level;

    modport source (output valid, output point_x_mm, output point_y_mm,
                    output point_z_mm, output gray_level, input ready);
    modport sink   (input valid, input point_x_mm, input point_y_mm,
                    input point_z_mm, input gray_level, output ready);
endinterface

`default_nettype wire

@@ sv/dpb_cfg_if.sv @@
// ============================================================================
// dpb_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ============================================================================
`default_nettype none

interface dpb_cfg_if
    import dpb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/dpb_front.sv @@
// ============================================================================
// dpb_front
// Tracks column and row of the raster stream, drops non-positive depths and
// queues the pixel offsets from the frame center for the back end.
// ============================================================================
`default_nettype none

module dpb_front
    import dpb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    dpb_pixel_if.sink        pixel,
    output qitem_t           push_data,
    output logic             push_valid,
    input  wire logic        push_ready
);

    logic [CNT_W-1:0]  col_reg, col_next;
    logic [RCNT_W-1:0] row_reg, row_next;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [CNT_W-1:0]  cur_col;
    logic [RCNT_W-1:0] cur_row;
    logic [CMP_W-1:0]  col_inc;
    logic [CMP_W-1:0]  row_inc;
    logic              accept;
    logic              depth_pos;

    always_comb
    begin
        if (cfg.frame_width == '0)
            w_eff = DIM_W'(1);
        else if (int'(cfg.frame_width) > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = cfg.frame_width;

        if (cfg.frame_height == '0)
            h_eff = DIM_W'(1);
        else if (int'(cfg.frame_height) > MAX_HEIGHT)
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = cfg.frame_height;
    end

    assign pixel.ready = push_ready;
    assign accept      = pixel.valid && pixel.ready;
    assign depth_pos   = !pixel.depth_mm[DEPTH_W-1] && (pixel.depth_mm != '0);

    // A frame start places this very pixel at column 0, row 0.
    assign cur_col = pixel.frame_start ? '0 : col_reg;
    assign cur_row = pixel.frame_start ? '0 : row_reg;

    assign col_inc = CMP_W'(cur_col) + CMP_W'(1);
    assign row_inc = CMP_W'(cur_row) + CMP_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            col_next = cur_col + CNT_W'(1);
            row_next = cur_row;
            if (col_inc >= CMP_W'(w_eff))
            begin
                col_next = '0;
                row_next = cur_row + RCNT_W'(1);
                if (row_inc >= CMP_W'(h_eff))
                    row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        push_data.ofs_x = $signed(OFS_W'(cur_col)) - $signed(OFS_W'(w_eff[DIM_W-1:1]));
        push_data.ofs_y = $signed(OFS_W'(cur_row)) - $signed(OFS_W'(h_eff[DIM_W-1:1]));
        push_data.depth = pixel.depth_mm[MAG_W-1:0];
    end

    assign push_valid = accept && depth_pos;

endmodule

`default_nettype wire

@@ sv/dpb_queue.sv @@
// ============================================================================
// dpb_queue
// Short first-in first-out queue that decouples the front from the back.
// ============================================================================
`default_nettype none

module dpb_queue
    import dpb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire qitem_t push_data,
    input  wire logic   push_valid,
    output logic        push_ready,
    output qitem_t      pop_data,
    output logic        pop_valid,
    input  wire logic   pop_ready
);

    qitem_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ sv/dpb_back.sv @@
// ============================================================================
// dpb_back
// Projects one queued pixel to a 3D point and a gray shade over a short
// multiply sequence, then holds the point in an output register.
// ============================================================================
`default_nettype none

module dpb_back
    import dpb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire qitem_t pop_data,
    input  wire logic   pop_valid,
    output logic        pop_ready,
    dpb_point_if.source point
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL1  = 4'b0010,
        ST_MUL2  = 4'b0100,
        ST_ROUND = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic signed [OFS_W-1:0]   ofs_x_reg;
    logic signed [OFS_W-1:0]   ofs_y_reg;
    logic [MAG_W-1:0]          depth_reg;
    logic signed [PD_W-1:0]    px1_reg;
    logic signed [PD_W-1:0]    py1_reg;
    logic [T_W-1:0]            t_reg;
    logic signed [PP_W-1:0]    px2_reg;
    logic signed [PP_W-1:0]    py2_reg;
    logic [GRAY_W-1:0]         gray_reg;

    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic signed [DEPTH_W-1:0] out_z_reg;
    logic [GRAY_W-1:0]         out_gray_reg;

    logic                      out_free;
    logic                      take;
    logic                      load_out;
    logic [VDIST_W:0]          shade_rem;
    logic [VDIST_W+GRAY_W:0]   shade_acc;
    logic [GRAY_W-1:0]         gray_calc;

    // Rounds a Q24 product half away from zero and saturates it. With flip
    // set the result is negated, and its magnitude is then clamped to the positive
    // limit whatever its sign.
    function automatic logic signed [COORD_W-1:0] scale_coord(
        input logic signed [PP_W-1:0] p,
        input logic                   flip
    );
        logic              neg;
        logic [PP_W-1:0]   mag;
        logic [PP_W:0]     sum;
        logic [M_W-1:0]    m;
        logic [M_W-1:0]    cap;
        logic [COORD_W-1:0] val;
        neg = p[PP_W-1];
        mag = neg ? PP_W'(-p) : PP_W'(p);
        sum = {1'b0, mag} + ((PP_W+1)'(1) << (FRAC_W - 1));
        m   = sum[PP_W:FRAC_W];
        cap = (neg && !flip) ? (M_W'(1) << (COORD_W - 1))
                             : ((M_W'(1) << (COORD_W - 1)) - M_W'(1));
        val = (m > cap) ? COORD_W'(cap) : COORD_W'(m);
        return (neg ^ flip) ? $signed(-val) : $signed(val);
    endfunction

    assign out_free  = !out_valid_reg || point.ready;
    assign pop_ready = (state_reg == ST_IDLE) || ((state_reg == ST_ROUND) && out_free);
    assign take      = pop_valid && pop_ready;
    assign load_out  = (state_reg == ST_ROUND) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = ST_MUL1;
            end
            ST_MUL1:
                state_next = ST_MUL2;
            ST_MUL2:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (out_free)
                    state_next = take ? ST_MUL1 : ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (point.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Shade: 65535 * (1 - t) rounded, where t is a Q32 fraction; a t of one or more gives zero.
    always_comb
    begin
        shade_rem = ((VDIST_W+1)'(1) << VDIST_W) - (VDIST_W+1)'(t_reg[VDIST_W-1:0]);
        shade_acc = ((VDIST_W+GRAY_W+1)'(shade_rem) << GRAY_W)
                  - (VDIST_W+GRAY_W+1)'(shade_rem)
                  + ((VDIST_W+GRAY_W+1)'(1) << (VDIST_W - 1));
        if (t_reg[T_W-1:VDIST_W] != '0)
            gray_calc = '0;
        else
            gray_calc = shade_acc[VDIST_W+GRAY_W-1:VDIST_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ofs_x_reg <= pop_data.ofs_x;
            ofs_y_reg <= pop_data.ofs_y;
            depth_reg <= pop_data.depth;
        end
        if (state_reg == ST_MUL1)
        begin
            px1_reg <= PD_W'(ofs_x_reg) * $signed(PD_W'({1'b0, depth_reg}));
            py1_reg <= PD_W'(ofs_y_reg) * $signed(PD_W'({1'b0, depth_reg}));
            t_reg   <= T_W'(depth_reg) * T_W'(cfg.inv_view_distance_q32);
        end
        if (state_reg == ST_MUL2)
        begin
            px2_reg  <= PP_W'(px1_reg) * $signed(PP_W'({1'b0, cfg.inv_focal_q24}));
            py2_reg  <= PP_W'(py1_reg) * $signed(PP_W'({1'b0, cfg.inv_focal_q24}));
            gray_reg <= gray_calc;
        end
        if (load_out)
        begin
            out_x_reg    <= scale_coord(px2_reg, 1'b0);
            out_y_reg    <= scale_coord(py2_reg, 1'b1);
            out_z_reg    <= -$signed({1'b0, depth_reg});
            out_gray_reg <= gray_reg;
        end
    end

    assign point.valid      = out_valid_reg;
    assign point.point_x_mm = out_x_reg;
    assign point.point_y_mm = out_y_reg;
    assign point.point_z_mm = out_z_reg;
    assign point.gray_level = out_gray_reg;

endmodule

`default_nettype wire

@@ sv/depth_pixel_backprojection.sv @@
// ============================================================================
// depth_pixel_backprojection
// Back-projects a raster stream of depth samples to pinhole 3D points.
// ============================================================================
// Depth pixels enter one per cycle on the pixel channel while the queue has
// room; pixels with depth zero or below only advance the column and row
// counters and produce no point. Each point passes through the back end's
// two multiply stages and the rounding stage, and the back end takes no new
// pixel before the last one reaches the output register; the four-entry queue
// and the output register absorb short bursts and stalls on either side.
// Configuration writes are taken at any time on the cfg channel and should
// be issued only while no pixel is in flight.
`default_nettype none

module depth_pixel_backprojection
    import dpb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dpb_pixel_if.sink   pixel,
    dpb_point_if.source point,
    dpb_cfg_if.sink     cfg
);

    cfg_t   cfg_reg;
    qitem_t push_data;
    logic   push_valid;
    logic   push_ready;
    qitem_t pop_data;
    logic   pop_valid;
    logic   pop_ready;

    assign cfg.ready = 1'b1;

    // Writes to an index past the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width           <= RST_FRAME_WIDTH;
            cfg_reg.frame_height          <= RST_FRAME_HEIGHT;
            cfg_reg.inv_focal_q24         <= RST_INV_FOCAL;
            cfg_reg.inv_view_distance_q32 <= RST_INV_VIEW_DIST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:       cfg_reg.frame_width <= cfg.data[DIM_W-1:0];
                REG_FRAME_HEIGHT:      cfg_reg.frame_height <= cfg.data[DIM_W-1:0];
                REG_INV_FOCAL_Q24:     cfg_reg.inv_focal_q24 <= cfg.data[FOCAL_W-1:0];
                REG_INV_VIEW_DIST_Q32: cfg_reg.inv_view_distance_q32 <= cfg.data[VDIST_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    dpb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pixel      (pixel),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    dpb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    dpb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .point     (point)
    );

endmodule

`default_nettype wire

@@ test/depth_pixel_backprojection_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// depth_pixel_backprojection_test
// Self-checking bench for the depth pixel back-projection block. A directed
// run covers depth and coordinate extremes, clamped geometry and counters
// left past a shrunk frame. Random frames then run under several register
// settings. A scoreboard predicts every point from its own copy of the
// registers and the raster counters, and checks each point beat on arrival.
// ============================================================================

module depth_pixel_backprojection_test;
    import dpb_pkg::*;

    localparam int  REG_COUNT      = 4;
    localparam int  QUIET_CYCLES   = 24;
    localparam int  HOLD_AFTER     = 150;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  MAX_REPORTS    = 60;
    localparam longint COORD_HI    = 64'sd16777215;
    localparam longint COORD_LO    = -64'sd16777216;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_mm;
        logic signed [COORD_W-1:0] y_mm;
        logic signed [DEPTH_W-1:0] z_mm;
        logic [GRAY_W-1:0]         gray;
    } point_t;

    // Predicts the point stream from accepted pixels and register writes.
    class point_scoreboard;
        logic [DIM_W-1:0]   width_reg;
        logic [DIM_W-1:0]   height_reg;
        logic [FOCAL_W-1:0] focal_reg;
        logic [VDIST_W-1:0] vdist_reg;
        int unsigned        col;
        int unsigned        row;
        point_t             expected_points[$];
        int                 errors;

        function new();
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            focal_reg  = RST_INV_FOCAL;
            vdist_reg  = RST_INV_VIEW_DIST;
            col        = 0;
            row        = 0;
            errors     = 0;
        endfunction

        function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
            if (v == 0)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        function int unsigned frame_w();
            return clamp_dim(width_reg, MAX_WIDTH);
        endfunction

        function int unsigned frame_h();
            return clamp_dim(height_reg, MAX_HEIGHT);
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:       width_reg  = data[DIM_W-1:0];
                REG_FRAME_HEIGHT:      height_reg = data[DIM_W-1:0];
                REG_INV_FOCAL_Q24:     focal_reg  = data[FOCAL_W-1:0];
                REG_INV_VIEW_DIST_Q32: vdist_reg  = data[VDIST_W-1:0];
                default: ;
            endcase
        endfunction

        // offset * depth * focal in Q24, rounded half away from zero, saturated.
        function longint scale_offset(longint ofs, longint d);
            longint          f;
            longint          prod;
            longint          r;
            longint unsigned mag;
            f    = focal_reg;
            prod = ofs * d * f;
            mag  = (prod < 0) ? -prod : prod;
            r    = longint'((mag + 64'd8388608) >> 24);
            if (prod < 0)
                r = -r;
            if (r > COORD_HI)
                r = COORD_HI;
            if (r < COORD_LO)
                r = COORD_LO;
            return r;
        endfunction

        function logic [GRAY_W-1:0] shade_of(longint d);
            longint unsigned t;
            longint unsigned v;
            longint unsigned g;
            v = vdist_reg;
            t = longint'(d) * v;
            if (t >= 64'h1_0000_0000)
                return '0;
            g = ((64'h1_0000_0000 - t) * 64'd65535 + 64'h8000_0000) >> 32;
            return g[GRAY_W-1:0];
        endfunction

        function void note_pixel(logic signed [DEPTH_W-1:0] depth, logic fs);
            int unsigned w;
            int unsigned h;
            longint      d;
            longint      x;
            longint      y;
            point_t      p;
            w = frame_w();
            h = frame_h();
            d = depth;
            if (fs)
            begin
                col = 0;
                row = 0;
            end
            if (d > 0)
            begin
                x = scale_offset(longint'(col) - longint'(w / 2), d);
                y = -scale_offset(longint'(row) - longint'(h / 2), d);
                if (y > COORD_HI)
                    y = COORD_HI;
                p.x_mm = x[COORD_W-1:0];
                p.y_mm = y[COORD_W-1:0];
                p.z_mm = -depth;
                p.gray = shade_of(d);
                expected_points.push_back(p);
            end
            col++;
            if (col >= w)
            begin
                col = 0;
                row++;
                if (row >= h)
                    row = 0;
            end
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: point %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (expected_points.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: point beat with no pixel pending, expected none, actual %0d %0d %0d %0d",
                             $time, got.x_mm, got.y_mm, got.z_mm, got.gray);
                return;
            end
            want = expected_points.pop_front();
            check_field("x", longint'(want.x_mm), longint'(got.x_mm));
            check_field("y", longint'(want.y_mm), longint'(got.y_mm));
            check_field("z", longint'(want.z_mm), longint'(got.z_mm));
            check_field("gray", longint'(want.gray), longint'(got.gray));
        endfunction

        function void finish_check();
            if (expected_points.size() != 0)
            begin
                errors++;
                $display("%0t: points missing at end, expected %0d more, actual 0",
                         $time, expected_points.size());
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dpb_pixel_if pixel_ch();
    dpb_point_if point_ch();
    dpb_cfg_if   cfg_ch();

    point_scoreboard sb = new();
    int              sent_count = 0;

    depth_pixel_backprojection u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .point (point_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int draw_send_gap();
        if (sent_count % 64 < 16)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic signed [DEPTH_W-1:0] nonpositive_depth();
        return DEPTH_W'(-int'($urandom_range(0, 32768)));
    endfunction

    function automatic logic signed [DEPTH_W-1:0] random_depth();
        case ($urandom_range(0, 9))
            0: return 16'sd32767;
            1: return 16'sd1;
            7: return DEPTH_W'($urandom);
            8: return '0;
            9: return nonpositive_depth();
            default: return DEPTH_W'($urandom_range(1, 32767));
        endcase
    endfunction

    // Valid stays high across back-to-back beats; it drops only for a gap.
    task automatic send_pixel(input logic signed [DEPTH_W-1:0] depth, input logic fs,
                              input int gap);
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid       <= 1'b1;
        pixel_ch.depth_mm    <= depth;
        pixel_ch.frame_start <= fs;
        do @(posedge clk); while (pixel_ch.ready !== 1'b1);
        sb.note_pixel(depth, fs);
        sent_count++;
    endtask

    task automatic send_filler(input int n);
        repeat (n) send_pixel(nonpositive_depth(), 1'b0, 0);
    endtask

    // Stop offering pixels and wait for every pending point; with quiet set,
    // also give the front end time to retire pixels that make no point.
    task automatic settle(input bit quiet);
        pixel_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        if (quiet)
            repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        sb.note_config(idx, data);
    endtask

    // Unused upper data bits are randomized; the block must drop them.
    task automatic apply_setting(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                 input logic [FOCAL_W-1:0] f, input logic [VDIST_W-1:0] v);
        write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2 ** CFG_IDX_W - 1)), $urandom);
        write_reg(REG_FRAME_WIDTH, ($urandom & ~32'h7FF) | CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, ($urandom & ~32'h7FF) | CFG_DATA_W'(h));
        write_reg(REG_INV_FOCAL_Q24, ($urandom & 32'hFF00_0000) | CFG_DATA_W'(f));
        write_reg(REG_INV_VIEW_DIST_Q32, v);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly frame_start runs of up to 150 pixels, mixed with short broken runs.
    task automatic run_frames(input int count, input bit pause_midway);
        int sent;
        int len;
        int k;
        bit whole;
        logic fs;
        sent = 0;
        while (sent < count)
        begin
            whole = ($urandom_range(0, 9) < 7);
            if (whole)
            begin
                len = sb.frame_w() * sb.frame_h();
                if (len > 150)
                    len = $urandom_range(20, 150);
            end
            else
                len = $urandom_range(1, 30);
            for (k = 0; k < len && sent < count; k++)
            begin
                fs = whole ? (k == 0) : ($urandom_range(0, 15) == 0);
                send_pixel(random_depth(), fs, draw_send_gap());
                sent++;
                if (pause_midway && sent == count / 2)
                    settle(1'b0);
            end
        end
    endtask

    initial
    begin : point_sink
        int   gap;
        int   taken;
        bit   held;
        point_t got;
        taken = 0;
        held  = 1'b0;
        point_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && taken == HOLD_AFTER)
            begin
                // Long back-pressure so the queue fills and the input stalls.
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            else if (taken % 80 < 20)
                gap = 0;
            else
                gap = $urandom_range(0, 16);
            if (gap > 0)
            begin
                point_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            point_ch.ready <= 1'b1;
            do @(posedge clk); while (point_ch.valid !== 1'b1);
            got.x_mm = point_ch.point_x_mm;
            got.y_mm = point_ch.point_y_mm;
            got.z_mm = point_ch.point_z_mm;
            got.gray = point_ch.gray_level;
            sb.check_point(got);
            taken++;
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) ||
                (point_ch.valid === 1'b1 && point_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("depth_pixel_backprojection verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int ph;
        int k;
        pixel_ch.valid       <= 1'b0;
        pixel_ch.depth_mm    <= '0;
        pixel_ch.frame_start <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: depth extremes, zero and negative depths.
        send_pixel(16'sd32767, 1'b1, 0);
        send_pixel(16'sd1, 1'b0, 0);
        send_pixel(16'sd0, 1'b0, 0);
        send_pixel(-16'sd1, 1'b0, 0);
        send_pixel(-16'sd32768, 1'b0, 2);
        send_pixel(16'sd12345, 1'b0, 5);
        settle(1'b1);

        // Tiny frame with the largest reciprocals; runs past one frame wrap.
        apply_setting(11'd4, 11'd3, 24'hFF_FFFF, 32'hFFFF_FFFF);
        for (k = 0; k < 14; k++)
            send_pixel((k == 0) ? 16'sd32767 : random_depth(), k == 0, 0);
        settle(1'b1);

        // Walk the row counter well past the frame center, then shrink the
        // frame under it so y saturates and the row wraps on the next pixel.
        apply_setting(11'd1, 11'd1024, 24'hFF_FFFF, 32'd0);
        send_pixel(nonpositive_depth(), 1'b1, 0);
        send_filler(538);
        settle(1'b1);
        apply_setting(11'd1, 11'd1, 24'hFF_FFFF, 32'd0);
        send_pixel(16'sd32767, 1'b0, 0);
        send_pixel(16'sd32767, 1'b0, 0);
        send_pixel(16'sd100, 1'b0, 0);
        settle(1'b1);

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: apply_setting(11'd0, 11'd0, 24'd0, 32'd0);
                1: apply_setting(11'd2047, 11'd1025, 24'd1, 32'd1);
                2: apply_setting(11'd1, 11'd1024, FOCAL_W'($urandom >> $urandom_range(8, 31)),
                                 $urandom >> $urandom_range(0, 31));
                3: apply_setting(11'd1024, 11'd1, FOCAL_W'($urandom >> $urandom_range(8, 31)),
                                 $urandom >> $urandom_range(0, 31));
                default: apply_setting(DIM_W'($urandom_range(1, 12)), DIM_W'($urandom_range(1, 12)),
                                       FOCAL_W'($urandom >> $urandom_range(8, 31)),
                                       $urandom >> $urandom_range(0, 31));
            endcase
            run_frames(60, ph == 4);
            settle(1'b1);
        end

        sb.finish_check();
        if (sb.errors == 0)
            $display("depth_pixel_backprojection verification clean");
        else
            $display("depth_pixel_backprojection verification failed");
        $finish;
    end

endmodule
